// ----- sv/s2c_pkg.sv -----
// Shared types, constants and the month-length table for the seconds-to-calendar block.
package s2c_pkg;

  localparam logic [31:0] EPOCH_RESET = 32'd3155673600;

  localparam int DIV_W     = 6;   // widest constant divisor (60) fits here
  localparam int DIV_STEPS = 2;   // quotient step, then remainder step
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int DAYS_W    = 16;  // 2^32 seconds is under 49711 days
  localparam int YEAR_W    = 8;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;

  localparam logic [DIV_W-1:0] SEC_PER_MIN  = 6'd60;
  localparam logic [DIV_W-1:0] MIN_PER_HOUR = 6'd60;
  localparam logic [DIV_W-1:0] HOUR_PER_DAY = 6'd24;

  // reciprocals: floor(x / d) == (x * RECIP) >> SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_60       = 32'h8888_8889;  // ceil(2^37 / 60)
  localparam int          RECIP_SHIFT_60 = 37;
  localparam logic [31:0] RECIP_24       = 32'hAAAA_AAAB;  // ceil(2^36 / 24)
  localparam int          RECIP_SHIFT_24 = 36;

  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 16'd365;
  localparam logic [DAYS_W-1:0] DAYS_PER_QUAD = 16'd1461;  // one leap year plus three plain years
  localparam logic [YEAR_W-1:0] YEARS_PER_QUAD = 8'd4;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIV,
    OP_QUAD,
    OP_YEAR,
    OP_MONTH
  } dp_op_t;

  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
    logic     capture;
    logic     publish;
  } dp_cmd_t;

  typedef struct packed {
    logic below;
    logic quad_ge;
    logic year_ge;
    logic month_done;
  } dp_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/s2c_datapath.sv -----
// Datapath: offset register, shared reciprocal divider, year/month reduction, result registers.
module s2c_datapath import s2c_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [31:0]         in_seconds_since_1900,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  output logic [YEAR_W-1:0]   out_year_offset,
  output logic [MONTH_W-1:0]  out_month,
  output logic [DAY_W-1:0]    out_day,
  output logic [4:0]          out_hour,
  output logic [5:0]          out_minute,
  output logic [5:0]          out_second,
  output logic                out_before_epoch
);

  logic [31:0]        offset_r;
  logic [31:0]        acc_r;
  logic [31:0]        quo_r;
  logic               before_r;
  logic [5:0]         sec_r;
  logic [5:0]         min_r;
  logic [4:0]         hr_r;
  logic [DAYS_W-1:0]  days_r;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic               out_valid_r;
  logic [YEAR_W-1:0]  out_year_r;
  logic [MONTH_W-1:0] out_month_r;
  logic [DAY_W-1:0]   out_day_r;
  logic [4:0]         out_hour_r;
  logic [5:0]         out_minute_r;
  logic [5:0]         out_second_r;
  logic               out_before_r;

  logic [DIV_W-1:0]   div_val;
  logic [31:0]        recip;
  logic [63:0]        prod;
  logic [31:0]        quo;
  logic [31:0]        quo_mul;
  logic [31:0]        rem_full;
  logic               leap;
  logic [DAYS_W-1:0]  ylen;
  logic [DAY_W-1:0]   mlen;

  always_comb begin
    unique case (cmd.sel)
      DIV_SEC: begin
        div_val = SEC_PER_MIN;
        recip   = RECIP_60;
      end
      DIV_MIN: begin
        div_val = MIN_PER_HOUR;
        recip   = RECIP_60;
      end
      DIV_HOUR: begin
        div_val = HOUR_PER_DAY;
        recip   = RECIP_24;
      end
      default: begin
        div_val = SEC_PER_MIN;
        recip   = RECIP_60;
      end
    endcase
    // quotient by reciprocal multiply, remainder from the registered quotient
    prod     = {32'd0, acc_r} * {32'd0, recip};
    quo      = (cmd.sel == DIV_HOUR) ?
               {{(RECIP_SHIFT_24-32){1'b0}}, prod[63:RECIP_SHIFT_24]} :
               {{(RECIP_SHIFT_60-32){1'b0}}, prod[63:RECIP_SHIFT_60]};
    quo_mul  = quo_r * {{(32-DIV_W){1'b0}}, div_val};
    rem_full = acc_r - quo_mul;

    leap = (year_r[1:0] == 2'd0);
    ylen = DAYS_PER_YEAR + {{(DAYS_W-1){1'b0}}, leap};
    mlen = month_len(month_r, leap);

    sts.below      = before_r;
    sts.quad_ge    = days_r >= DAYS_PER_QUAD;
    sts.year_ge    = days_r >= ylen;
    sts.month_done = (days_r < {{(DAYS_W-DAY_W){1'b0}}, mlen}) || (month_r >= MONTH_DEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= EPOCH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        offset_r <= cfg_wdata;
      end
      out_valid_r <= cmd.publish;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        acc_r    <= in_seconds_since_1900 - offset_r;
        before_r <= in_seconds_since_1900 < offset_r;
      end
      OP_DIV: begin
        if (cmd.capture) begin
          acc_r <= quo_r;
          unique case (cmd.sel)
            DIV_SEC:  sec_r <= rem_full[5:0];
            DIV_MIN:  min_r <= rem_full[5:0];
            DIV_HOUR: begin
              hr_r    <= rem_full[4:0];
              days_r  <= quo_r[DAYS_W-1:0];
              year_r  <= '0;
              month_r <= MONTH_JAN;
            end
            default: ;
          endcase
        end else begin
          quo_r <= quo;
        end
      end
      OP_QUAD: begin
        days_r <= days_r - DAYS_PER_QUAD;
        year_r <= year_r + YEARS_PER_QUAD;
      end
      OP_YEAR: begin
        days_r <= days_r - ylen;
        year_r <= year_r + 8'd1;
      end
      OP_MONTH: begin
        days_r  <= days_r - {{(DAYS_W-DAY_W){1'b0}}, mlen};
        month_r <= month_r + 4'd1;
      end
      default: ;
    endcase

    if (cmd.publish) begin
      if (before_r) begin
        out_year_r   <= '0;
        out_month_r  <= '0;
        out_day_r    <= '0;
        out_hour_r   <= '0;
        out_minute_r <= '0;
        out_second_r <= '0;
        out_before_r <= 1'b1;
      end else begin
        out_year_r   <= year_r;
        out_month_r  <= month_r;
        out_day_r    <= days_r[DAY_W-1:0] + 5'd1;
        out_hour_r   <= hr_r;
        out_minute_r <= min_r;
        out_second_r <= sec_r;
        out_before_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_year_offset  = out_year_r;
  assign out_month        = out_month_r;
  assign out_day          = out_day_r;
  assign out_hour         = out_hour_r;
  assign out_minute       = out_minute_r;
  assign out_second       = out_second_r;
  assign out_before_epoch = out_before_r;

endmodule

// ----- sv/s2c_ctrl.sv -----
// Controller: sequences load, three divisions, year and month reduction, and result publish.
module s2c_ctrl import s2c_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_SEC,
    ST_DIV_MIN,
    ST_DIV_HOUR,
    ST_QUAD,
    ST_YEAR,
    ST_MONTH
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.op      = OP_IDLE;
    cmd.sel     = DIV_SEC;
    cmd.capture = 1'b0;
    cmd.publish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_nxt = '0;
        if (sts.below) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_DIV_SEC;
        end
      end
      ST_DIV_SEC, ST_DIV_MIN, ST_DIV_HOUR: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        unique case (state_r)
          ST_DIV_MIN:  cmd.sel = DIV_MIN;
          ST_DIV_HOUR: cmd.sel = DIV_HOUR;
          default:     cmd.sel = DIV_SEC;
        endcase
        if (cnt_r == CNT_LAST) begin
          cmd.capture = 1'b1;
          unique case (state_r)
            ST_DIV_SEC: state_nxt = ST_DIV_MIN;
            ST_DIV_MIN: state_nxt = ST_DIV_HOUR;
            default:    state_nxt = ST_QUAD;
          endcase
        end
      end
      ST_QUAD: begin
        if (sts.quad_ge) begin
          cmd.op = OP_QUAD;
        end else begin
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts.year_ge) begin
          cmd.op = OP_YEAR;
        end else begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (!sts.month_done) begin
          cmd.op = OP_MONTH;
        end else begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ----- sv/seconds_to_calendar.sv -----
// Top level: seconds since 1900 to calendar fields relative to a programmable epoch.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ------------------------------------
//  request   in_seconds_since_1900                   taken when start && !busy
//  result    out_year_offset .. out_before_epoch     out_valid high for exactly one cycle
//  config    cfg_wdata                               written when cfg_we is high
//
// A request below the epoch has its comparison registered at the load and is then
// published, with out_before_epoch set and every other field zero. Otherwise the
// result follows the load, the check and three divisions (by 60, 60, 24) in the shared
// reciprocal divider, each a quotient step and a remainder step, then up to 34 four-year
// strides, up to 3 single years and up to 11 months in the day-count subtractor, and
// is published once the months are done.
// busy falls in the cycle the result is shown; a new request may be taken right then.
// Reset (rst_n low, synchronous) returns the controller to idle, drops out_valid and
// loads the epoch register with 2000-01-01. Results cannot be held off by the receiver.
module seconds_to_calendar import s2c_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [31:0]         in_seconds_since_1900,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  output logic [YEAR_W-1:0]   out_year_offset,
  output logic [MONTH_W-1:0]  out_month,
  output logic [DAY_W-1:0]    out_day,
  output logic [4:0]          out_hour,
  output logic [5:0]          out_minute,
  output logic [5:0]          out_second,
  output logic                out_before_epoch
);

  // command and status between the sequencer and the arithmetic
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns busy and decides every datapath step
  s2c_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // arithmetic: epoch subtract, divider, year/month walk, result registers
  s2c_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_seconds_since_1900 (in_seconds_since_1900),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_year_offset       (out_year_offset),
    .out_month             (out_month),
    .out_day               (out_day),
    .out_hour              (out_hour),
    .out_minute            (out_minute),
    .out_second            (out_second),
    .out_before_epoch      (out_before_epoch)
  );

endmodule

// ----- sv/s2c_checker.sv -----
// Port-level checker for the seconds-to-calendar block, bound to the top level.
module s2c_checker import s2c_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [YEAR_W-1:0]  out_year_offset,
  input logic [MONTH_W-1:0] out_month,
  input logic [DAY_W-1:0]   out_day,
  input logic [4:0]         out_hour,
  input logic [5:0]         out_minute,
  input logic [5:0]         out_second,
  input logic               out_before_epoch
);

  // a taken request keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // one result per request: strobes never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  // the result shows only once the block is idle again
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // below the epoch every field is zero
  a_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_before_epoch |->
      out_year_offset == '0 && out_month == '0 && out_day == '0 &&
      out_hour == '0 && out_minute == '0 && out_second == '0)
    else $error("nonzero fields on a before-epoch result");

  // a dated result lies inside the calendar ranges
  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_before_epoch |->
      out_month >= MONTH_JAN && out_month <= MONTH_DEC && out_day != '0 &&
      out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60)
    else $error("calendar field out of range");

endmodule

bind seconds_to_calendar s2c_checker u_s2c_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for seconds_to_calendar: driver, monitor and calendar predictor.
`timescale 1ns / 1ps

module testbench;
  import s2c_pkg::*;

  // Constants of the calendar arithmetic, kept apart from the block's own package copies.
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned YEAR_DAYS     = 365;
  localparam int unsigned LEAP_EVERY    = 4;
  localparam int unsigned LAST_MONTH    = 12;

  // Quiet cycles allowed: the limit lies well above the slowest conversion plus the
  // longest gap the driver inserts, so it leaves a wide margin.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Drain time after the last result; covers the longest conversion.
  localparam int unsigned DRAIN_CYCLES = 160;

  typedef enum bit {
    KIND_SECONDS,
    KIND_EPOCH
  } pend_kind_t;

  typedef struct {
    pend_kind_t  kind;
    logic [31:0] value;
  } pend_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year_offset;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic               before_epoch;
  } cal_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        in_seconds_since_1900 = '0;
  logic               cfg_we = 1'b0;
  logic [31:0]        cfg_wdata = '0;
  logic               out_valid;
  logic [YEAR_W-1:0]  out_year_offset;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;
  logic [4:0]         out_hour;
  logic [5:0]         out_minute;
  logic [5:0]         out_second;
  logic               out_before_epoch;

  pend_t       pending[$];       // requests and epoch writes still to be driven
  cal_t        calendar_due[$];  // calendars predicted for accepted requests, oldest first
  logic [31:0] epoch_now = EPOCH_RESET;  // predictor's copy of the epoch register
  int unsigned idle_left = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;

  seconds_to_calendar DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_seconds_since_1900 (in_seconds_since_1900),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_year_offset       (out_year_offset),
    .out_month             (out_month),
    .out_day               (out_day),
    .out_hour              (out_hour),
    .out_minute            (out_minute),
    .out_second            (out_second),
    .out_before_epoch      (out_before_epoch)
  );

  always #5 clk = ~clk;

  // Convert a count of seconds since 1900 into calendar fields relative to the epoch.
  // Leap years are every fourth year offset, with no century rule.
  function automatic cal_t calendar_of(logic [31:0] secs, logic [31:0] epoch);
    cal_t        r;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mo;
    int unsigned len;
    bit          leap;
    r = '0;
    if (secs < epoch) begin
      r.before_epoch = 1'b1;
      return r;
    end
    t = secs - epoch;
    r.second = 6'(t % SECS_PER_MIN);
    t = t / SECS_PER_MIN;
    r.minute = 6'(t % MINS_PER_HOUR);
    t = t / MINS_PER_HOUR;
    r.hour = 5'(t % HOURS_PER_DAY);
    days = t / HOURS_PER_DAY;
    // Strip whole years; leap holds the state of the year the day lands in.
    yr = 0;
    forever begin
      leap = (yr % LEAP_EVERY) == 0;
      len = leap ? YEAR_DAYS + 1 : YEAR_DAYS;
      if (days < len) break;
      days = days - len;
      yr++;
    end
    // Strip whole months; December absorbs whatever is left.
    mo = 1;
    forever begin
      case (mo)
        2:            len = leap ? 29 : 28;
        4, 6, 9, 11:  len = 30;
        default:      len = 31;
      endcase
      if (days < len || mo >= LAST_MONTH) break;
      days = days - len;
      mo++;
    end
    r.year_offset = YEAR_W'(yr);
    r.month = MONTH_W'(mo);
    r.day = DAY_W'(days + 1);
    return r;
  endfunction

  // Pick a count of seconds for the given epoch: mostly at or after it, spread
  // uniformly or pinned to the first or last second of a day, some below it,
  // and some with no regard to the epoch at all.
  function automatic logic [31:0] pick_seconds(logic [31:0] epoch);
    longint unsigned span;
    longint unsigned off;
    longint unsigned days;
    span = 64'hFFFF_FFFF - epoch;
    off = {$urandom, $urandom} % (span + 1);
    case ($urandom_range(9, 0))
      0, 1: return $urandom;
      2: return (epoch == 0) ? 32'd0 : $urandom_range(epoch - 1, 0);
      8, 9: begin
        days = span / SECS_PER_DAY;
        off = ($urandom % (days + 1)) * SECS_PER_DAY
              + ($urandom_range(1, 0) ? SECS_PER_DAY - 1 : 0);
        if (off > span) off = span;
      end
      default: ;
    endcase
    return epoch + off[31:0];
  endfunction

  task automatic queue_seconds(logic [31:0] secs);
    pending.push_back('{KIND_SECONDS, secs});
  endtask

  task automatic queue_epoch(logic [31:0] epoch);
    pending.push_back('{KIND_EPOCH, epoch});
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Driver: present one request at a time, hold start until the block takes it,
  // then idle for a random gap. Epoch writes wait until every predicted result
  // has come back and the block is no longer busy.
  always @(posedge clk) begin
    logic        nxt_start;
    logic        nxt_we;
    logic [31:0] nxt_secs;
    logic [31:0] nxt_wdata;
    bit          taken;
    nxt_start = start;
    nxt_we = 1'b0;
    nxt_secs = in_seconds_since_1900;
    nxt_wdata = cfg_wdata;
    taken = rst_n && start && !busy;
    if (taken) begin
      calendar_due.push_back(calendar_of(in_seconds_since_1900, epoch_now));
      nxt_start = 1'b0;
    end
    if (!rst_n) begin
      nxt_start = 1'b0;
      nxt_secs = '0;
      nxt_wdata = '0;
    end else if (start && !taken) begin
      // hold the request until the block is free
    end else if (idle_left != 0) begin
      idle_left--;
    end else if (pending.size() != 0) begin
      if (pending[0].kind == KIND_EPOCH) begin
        if (calendar_due.size() == 0 && !busy && !taken) begin
          nxt_we = 1'b1;
          nxt_wdata = pending[0].value;
          epoch_now = pending[0].value;
          void'(pending.pop_front());
        end
      end else begin
        nxt_start = 1'b1;
        nxt_secs = pending[0].value;
        void'(pending.pop_front());
        // Choose the gap after this request: runs with none, most often none, at times
        // short, now and then long enough to span a whole conversion.
        if (burst_left != 0) begin
          burst_left--;
          idle_left = 0;
        end else begin
          case ($urandom_range(29, 0))
            0:                  burst_left = $urandom_range(40, 20);
            1, 2:               idle_left = $urandom_range(200, 20);
            3, 4, 5, 6, 7, 8:   idle_left = $urandom_range(10, 1);
            default:            idle_left = 0;
          endcase
        end
      end
    end
    start <= nxt_start;
    in_seconds_since_1900 <= nxt_secs;
    cfg_we <= nxt_we;
    cfg_wdata <= nxt_wdata;
  end

  // Monitor: compare every strobed result with the oldest prediction, and
  // watch for the block going quiet for too long.
  always @(posedge clk) begin
    cal_t want;
    if (rst_n && out_valid) begin
      if (calendar_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got year %0d month %0d day %0d",
                 $time, out_year_offset, out_month, out_day);
        errors++;
      end else begin
        want = calendar_due.pop_front();
        check_field("year_offset", want.year_offset, out_year_offset);
        check_field("month", want.month, out_month);
        check_field("day", want.day, out_day);
        check_field("hour", want.hour, out_hour);
        check_field("minute", want.minute, out_minute);
        check_field("second", want.second, out_second);
        check_field("before_epoch", want.before_epoch, out_before_epoch);
      end
    end
    if (rst_n && (out_valid || (start && !busy))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request or result for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [31:0] ep;
    // Directed requests at the reset epoch (2000-01-01): below, at and just
    // past the epoch, minute/hour/day rollovers, the leap day, year ends and
    // the largest count.
    queue_seconds(32'd0);
    queue_seconds(EPOCH_RESET - 1);
    queue_seconds(EPOCH_RESET);
    queue_seconds(EPOCH_RESET + 59);
    queue_seconds(EPOCH_RESET + 60);
    queue_seconds(EPOCH_RESET + 3599);
    queue_seconds(EPOCH_RESET + 3600);
    queue_seconds(EPOCH_RESET + SECS_PER_DAY - 1);
    queue_seconds(EPOCH_RESET + SECS_PER_DAY);
    queue_seconds(EPOCH_RESET + 31 * SECS_PER_DAY);
    queue_seconds(EPOCH_RESET + 59 * SECS_PER_DAY);
    queue_seconds(EPOCH_RESET + 60 * SECS_PER_DAY);
    queue_seconds(EPOCH_RESET + 335 * SECS_PER_DAY);
    queue_seconds(EPOCH_RESET + 366 * SECS_PER_DAY - 1);
    queue_seconds(EPOCH_RESET + 366 * SECS_PER_DAY);
    queue_seconds(EPOCH_RESET + (366 + 59) * SECS_PER_DAY);
    queue_seconds(EPOCH_RESET + 1461 * SECS_PER_DAY);
    queue_seconds(32'hFFFF_FFFF);

    // Epoch at zero: the full 136-year range.
    queue_epoch(32'd0);
    queue_seconds(32'd0);
    queue_seconds(32'hFFFF_FFFF);
    repeat (110) queue_seconds(pick_seconds(32'd0));

    // Epoch at the top: only the largest count is not before it.
    queue_epoch(32'hFFFF_FFFF);
    queue_seconds(32'hFFFF_FFFE);
    queue_seconds(32'hFFFF_FFFF);
    repeat (20) queue_seconds(pick_seconds(32'hFFFF_FFFF));

    queue_epoch(32'h7FFF_FFFF);
    repeat (90) queue_seconds(pick_seconds(32'h7FFF_FFFF));

    // Two arbitrary epochs, then back to the default written explicitly.
    repeat (2) begin
      ep = $urandom;
      queue_epoch(ep);
      repeat (85) queue_seconds(pick_seconds(ep));
    end
    queue_epoch(EPOCH_RESET);
    repeat (130) queue_seconds(pick_seconds(EPOCH_RESET));

    // Hold reset, then release it.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: sample between edges so the driver's updates have settled.
    do @(negedge clk);
    while (pending.size() != 0 || start || calendar_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/s2c_pkg.sv
sv/s2c_datapath.sv
sv/s2c_ctrl.sv
sv/seconds_to_calendar.sv
sv/s2c_checker.sv
tb/testbench.sv
